FILE: design/imuaf_pkg.sv
// Shared constants, command and register codes, and lane control type
// for the IMU angle-follow filter. No dependencies.
package imuaf_pkg;

    localparam int ACCUM_WIDTH_DEF = 24;
    localparam int OUT_W           = 24;
    localparam int ANG_W           = 16;
    localparam int ALPHA_W         = 17;
    localparam int DIV_STEPS       = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic [15:0] AGE_RESET = 16'd200;

    localparam logic signed [17:0] WRAP_HALF = 18'sd18000;
    localparam logic signed [17:0] WRAP_FULL = 18'sd36000;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_HOLD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAU      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIT_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd5;

    typedef struct packed {
        logic capture;
        logic unwrap;
        logic diff;
        logic mul;
        logic filt;
        logic gain;
        logic cmp;
        logic publish;
    } t_lane_ctl;

endpackage

FILE: design/imuaf_div.sv
// Restoring divider for the filter coefficient: (s << 16) / (tau + s).
// One quotient bit per cycle. Depends on imuaf_pkg.
module imuaf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [15:0]                   i_s,
    input  logic [15:0]                   i_tau,
    output logic                          o_busy,
    output logic [imuaf_pkg::ALPHA_W-1:0] o_alpha
);
    import imuaf_pkg::*;

    localparam int CW = $clog2(DIV_STEPS);

    logic [31:0]   r_num;
    logic [16:0]   r_den;
    logic [16:0]   r_rem;
    logic [31:0]   r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [17:0]   w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_num[31]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_s, 16'd0};
            r_den <= {1'b0, i_tau} + {1'b0, i_s};
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= w_ge ? 17'(w_trial - {1'b0, r_den}) : w_trial[16:0];
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    assign o_busy  = r_busy;
    assign o_alpha = r_quo[ALPHA_W-1:0];
endmodule

FILE: design/imuaf_lane.sv
// One axis lane: angle unwrap, low-pass update, gain scaling and deadband
// check, stepped by the top-level sequencer. Depends on imuaf_pkg.
module imuaf_lane #(
    parameter int AW = imuaf_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  imuaf_pkg::t_lane_ctl                 i_ctl,
    input  logic signed [imuaf_pkg::ANG_W-1:0]   i_angle,
    input  logic [imuaf_pkg::ALPHA_W-1:0]        i_alpha,
    input  logic signed [15:0]                   i_gain,
    input  logic [15:0]                          i_deadband,
    output logic                                 o_pass,
    output logic signed [imuaf_pkg::OUT_W-1:0]   o_filt,
    output logic signed [imuaf_pkg::OUT_W-1:0]   o_sent
);
    import imuaf_pkg::*;

    localparam int SW = AW + 17;
    localparam int HW = AW + 1 - 16;
    localparam logic signed [SW-1:0] AW_MAX = SW'((64'sd1 <<< (AW - 1)) - 1);
    localparam logic signed [SW-1:0] AW_MIN = -AW_MAX - SW'(1);
    localparam logic signed [SW-1:0] O_MAX  = SW'((64'sd1 <<< (OUT_W - 1)) - 1);
    localparam logic signed [SW-1:0] O_MIN  = -O_MAX - SW'(1);

    function automatic logic signed [AW-1:0] sat_aw(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v > AW_MAX) ? AW_MAX : ((v < AW_MIN) ? AW_MIN : v);
        return c[AW-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [AW-1:0] v);
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] c;
        x = SW'(v);
        c = (x > O_MAX) ? O_MAX : ((x < O_MIN) ? O_MIN : x);
        return c[OUT_W-1:0];
    endfunction

    logic signed [ANG_W-1:0]      r_prev;
    logic signed [AW-1:0]         r_unw;
    logic signed [AW-1:0]         r_filt;
    logic signed [AW-1:0]         r_sent;
    logic signed [AW:0]           r_diff;
    logic [32:0]                  r_plo;
    logic signed [HW+17:0]        r_phi;
    logic signed [AW+15:0]        r_gp;
    logic signed [AW-1:0]         r_yt;

    logic signed [17:0]           w_step;
    logic signed [17:0]           w_wrap;
    logic [17:0]                  w_lo_rnd;
    logic signed [AW:0]           w_dd;
    logic [AW:0]                  w_mag;

    always_comb begin
        w_step = 18'(i_angle) - 18'(r_prev);
        if (w_step > WRAP_HALF) begin
            w_wrap = w_step - WRAP_FULL;
        end else if (w_step < -WRAP_HALF) begin
            w_wrap = w_step + WRAP_FULL;
        end else begin
            w_wrap = w_step;
        end
        w_lo_rnd = 18'((34'(r_plo) + 34'd32768) >> 16);
        w_dd     = (AW+1)'(r_yt) - (AW+1)'(r_sent);
        w_mag    = w_dd[AW] ? (AW+1)'(-w_dd) : w_dd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_unw  <= '0;
            r_filt <= '0;
            r_sent <= '0;
        end else if (i_ctl.capture) begin
            r_prev <= i_angle;
            r_unw  <= '0;
            r_filt <= '0;
            r_sent <= '0;
        end else begin
            if (i_ctl.unwrap) begin
                r_prev <= i_angle;
                r_unw  <= sat_aw(SW'(r_unw) + SW'(w_wrap));
            end
            if (i_ctl.filt) begin
                r_filt <= sat_aw(SW'(r_filt) + SW'(r_phi) + SW'(signed'({1'b0, w_lo_rnd})));
            end
            if (i_ctl.publish) begin
                r_sent <= r_yt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.diff) begin
            r_diff <= (AW+1)'(r_unw) - (AW+1)'(r_filt);
        end
        if (i_ctl.mul) begin
            r_plo <= 33'(i_alpha) * 33'(r_diff[15:0]);
            r_phi <= (HW+18)'(signed'({1'b0, i_alpha}) * signed'(r_diff[AW:16]));
        end
        if (i_ctl.gain) begin
            r_gp <= r_filt * i_gain;
        end
        if (i_ctl.cmp) begin
            r_yt <= sat_aw((SW'(r_gp) + SW'(128)) >>> 8);
        end
    end

    assign o_pass = w_mag >= (AW+1)'(i_deadband);
    assign o_filt = sat_out(r_filt);
    assign o_sent = sat_out(r_sent);
endmodule

FILE: design/imu_angle_follow_filter.sv
// IMU angle-follow filter: unwrap, low-pass, gain and deadband per tick.
// Ticks without filter work go from decode straight to the output register;
// a frame while following also runs unwrap, diff, coefficient divide, multiply,
// filter, gain, compare and publish. One item at a time; output stalls hold it.
// Reset: synchronous active-low; registers return to defaults, age to 200.
module imu_angle_follow_filter #(
    parameter int ACCUM_WIDTH = imuaf_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [imuaf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [imuaf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [15:0]                           i_elapsed,
    input  logic                                  i_new_frame,
    input  logic signed [15:0]                    i_yaw_angle,
    input  logic signed [15:0]                    i_pitch_angle,
    input  logic                                  i_gimbal_ready,
    input  logic                                  i_reference_ok,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [1:0]                            o_command,
    output logic signed [imuaf_pkg::OUT_W-1:0]    o_yaw_target,
    output logic signed [imuaf_pkg::OUT_W-1:0]    o_pitch_target,
    output logic                                  o_following,
    output logic signed [imuaf_pkg::OUT_W-1:0]    o_smoothed_yaw,
    output logic signed [imuaf_pkg::OUT_W-1:0]    o_smoothed_pitch,
    output logic [15:0]                           o_frame_age
);
    import imuaf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_UNW  = 4'd2;
    localparam logic [3:0] S_DIFF = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_FILT = 4'd6;
    localparam logic [3:0] S_GAIN = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_PUB  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic               r_enable;
    logic [15:0]        r_tau;
    logic signed [15:0] r_yaw_gain;
    logic signed [15:0] r_pit_gain;
    logic [15:0]        r_deadband;
    logic [15:0]        r_timeout;

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic               r_active;
    logic [15:0]        r_age;
    logic [1:0]         r_cmd;

    logic [15:0]        r_elapsed;
    logic               r_frame;
    logic signed [15:0] r_yaw;
    logic signed [15:0] r_pitch;
    logic               r_gready;
    logic               r_refok;

    logic               r_out_valid;
    logic [1:0]         r_o_cmd;
    logic signed [OUT_W-1:0] r_o_yt;
    logic signed [OUT_W-1:0] r_o_pt;
    logic               r_o_follow;
    logic signed [OUT_W-1:0] r_o_fy;
    logic signed [OUT_W-1:0] r_o_fp;
    logic [15:0]        r_o_age;

    t_lane_ctl          w_ctl;
    logic [16:0]        w_sum;
    logic [15:0]        w_s;
    logic               w_div_start;
    logic               w_div_busy;
    logic [ALPHA_W-1:0] w_alpha;
    logic               w_yaw_pass;
    logic               w_pit_pass;
    logic signed [OUT_W-1:0] w_yaw_filt;
    logic signed [OUT_W-1:0] w_pit_filt;
    logic signed [OUT_W-1:0] w_yaw_sent;
    logic signed [OUT_W-1:0] w_pit_sent;
    logic               w_out_free;
    logic               w_work;

    assign w_sum       = {1'b0, r_age} + {1'b0, r_elapsed};
    assign w_s         = w_sum[16] ? 16'hFFFF : w_sum[15:0];
    assign w_work      = r_enable && (r_elapsed != 16'd0) && r_gready && r_frame;
    assign w_div_start = (r_state == S_DEC) && w_work && r_active;
    assign w_out_free  = !r_out_valid || i_ready;
    assign o_ready     = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b1;
            r_tau      <= 16'd50;
            r_yaw_gain <= 16'sd256;
            r_pit_gain <= 16'sd256;
            r_deadband <= 16'd10;
            r_timeout  <= AGE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE:   r_enable   <= i_cfg_data[0];
                REG_TAU:      r_tau      <= i_cfg_data;
                REG_YAW_GAIN: r_yaw_gain <= i_cfg_data;
                REG_PIT_GAIN: r_pit_gain <= i_cfg_data;
                REG_DEADBAND: r_deadband <= i_cfg_data;
                REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_elapsed <= i_elapsed;
            r_frame   <= i_new_frame;
            r_yaw     <= i_yaw_angle;
            r_pitch   <= i_pitch_angle;
            r_gready  <= i_gimbal_ready;
            r_refok   <= i_reference_ok;
        end
    end

    always_comb begin
        w_ctl         = '0;
        n_state       = r_state;
        w_ctl.capture = (r_state == S_DEC) && w_work && !r_active && r_refok;
        w_ctl.unwrap  = (r_state == S_UNW);
        w_ctl.diff    = (r_state == S_DIFF);
        w_ctl.mul     = (r_state == S_MUL);
        w_ctl.filt    = (r_state == S_FILT);
        w_ctl.gain    = (r_state == S_GAIN);
        w_ctl.cmp     = (r_state == S_CMP);
        w_ctl.publish = (r_state == S_PUB) && (w_yaw_pass || w_pit_pass);
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_DEC;
            S_DEC:   n_state = (w_work && r_active) ? S_UNW : S_OUT;
            S_UNW:   n_state = S_DIFF;
            S_DIFF:  n_state = S_DIV;
            S_DIV:   if (!w_div_busy) n_state = S_MUL;
            S_MUL:   n_state = S_FILT;
            S_FILT:  n_state = S_GAIN;
            S_GAIN:  n_state = S_CMP;
            S_CMP:   n_state = S_PUB;
            S_PUB:   n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_age    <= AGE_RESET;
            r_cmd    <= CMD_NONE;
        end else begin
            r_state <= n_state;
            if (r_state == S_DEC) begin
                r_cmd <= CMD_NONE;
                if (r_enable && r_elapsed != 16'd0) begin
                    if (!r_gready) begin
                        r_active <= 1'b0;
                        r_age    <= '0;
                    end else if (r_frame) begin
                        if (r_active || r_refok) begin
                            r_age    <= '0;
                            r_active <= 1'b1;
                        end
                    end else begin
                        r_age <= w_s;
                        if (r_active && w_s > r_timeout) begin
                            r_cmd    <= CMD_HOLD;
                            r_active <= 1'b0;
                        end
                    end
                end
            end
            if (r_state == S_PUB) begin
                r_cmd <= (w_yaw_pass || w_pit_pass) ? CMD_SET : CMD_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_o_cmd    <= r_cmd;
            r_o_yt     <= (r_cmd == CMD_SET) ? w_yaw_sent : '0;
            r_o_pt     <= (r_cmd == CMD_SET) ? w_pit_sent : '0;
            r_o_follow <= r_active;
            r_o_fy     <= w_yaw_filt;
            r_o_fp     <= w_pit_filt;
            r_o_age    <= r_age;
        end
    end

    imuaf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_s     (w_s),
        .i_tau   (r_tau),
        .o_busy  (w_div_busy),
        .o_alpha (w_alpha)
    );

    imuaf_lane #(.AW(ACCUM_WIDTH)) u_lane_yaw (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_angle    (r_yaw),
        .i_alpha    (w_alpha),
        .i_gain     (r_yaw_gain),
        .i_deadband (r_deadband),
        .o_pass     (w_yaw_pass),
        .o_filt     (w_yaw_filt),
        .o_sent     (w_yaw_sent)
    );

    imuaf_lane #(.AW(ACCUM_WIDTH)) u_lane_pitch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_angle    (r_pitch),
        .i_alpha    (w_alpha),
        .i_gain     (r_pit_gain),
        .i_deadband (r_deadband),
        .o_pass     (w_pit_pass),
        .o_filt     (w_pit_filt),
        .o_sent     (w_pit_sent)
    );

    assign o_valid          = r_out_valid;
    assign o_command        = r_o_cmd;
    assign o_yaw_target     = r_o_yt;
    assign o_pitch_target   = r_o_pt;
    assign o_following      = r_o_follow;
    assign o_smoothed_yaw   = r_o_fy;
    assign o_smoothed_pitch = r_o_fp;
    assign o_frame_age      = r_o_age;

`ifndef SYNTH
    a_hold_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_command == CMD_HOLD |-> !o_following)
        else $error("hold item reports following");

    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_command != CMD_SET |-> o_yaw_target == '0 && o_pitch_target == '0)
        else $error("target set without set command");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> !w_div_busy)
        else $error("filter update before coefficient ready");

    a_set_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_command == CMD_SET |-> o_following && o_frame_age == 16'd0)
        else $error("set command outside follow mode");
`endif
endmodule

FILE: sim/imu_angle_follow_filter_check.sv
// Checker for the IMU angle-follow filter: watches both item channels,
// predicts each result from the accepted input items and compares fields.
// Depends on imuaf_pkg; configuration writes are mirrored from the cfg port.
`timescale 1ns / 100ps
module imu_angle_follow_filter_check (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [imuaf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [imuaf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [15:0]                          i_elapsed,
    input  logic                                 i_new_frame,
    input  logic signed [15:0]                   i_yaw_angle,
    input  logic signed [15:0]                   i_pitch_angle,
    input  logic                                 i_gimbal_ready,
    input  logic                                 i_reference_ok,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic [1:0]                           i_command,
    input  logic signed [23:0]                   i_yaw_target,
    input  logic signed [23:0]                   i_pitch_target,
    input  logic                                 i_following,
    input  logic signed [23:0]                   i_smoothed_yaw,
    input  logic signed [23:0]                   i_smoothed_pitch,
    input  logic [15:0]                          i_frame_age,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import imuaf_pkg::*;

    localparam longint ACC_HI = (64'sd1 <<< 23) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 23);

    typedef struct packed {
        logic [1:0]         command;
        logic signed [23:0] yaw_target;
        logic signed [23:0] pitch_target;
        logic               following;
        logic signed [23:0] smoothed_yaw;
        logic signed [23:0] smoothed_pitch;
        logic [15:0]        frame_age;
    } t_follow_result;

    t_follow_result target_queue[$];

    logic   cfg_enable;
    logic [15:0] cfg_tau, cfg_deadband, cfg_timeout;
    longint cfg_yaw_gain, cfg_pitch_gain;

    logic   st_active;
    longint st_prev_yaw, st_prev_pitch, st_unw_yaw, st_unw_pitch;
    longint st_filt_yaw, st_filt_pitch, st_sent_yaw, st_sent_pitch;
    logic [15:0] st_age;

    function automatic longint sat_acc(longint v);
        return v > ACC_HI ? ACC_HI : (v < ACC_LO ? ACC_LO : v);
    endfunction

    function automatic longint round_div(longint p, int sh);
        longint q;
        q = p + (64'sd1 <<< (sh - 1));
        return q >>> sh;
    endfunction

    function automatic longint wrap_delta(longint d);
        if (d > 18000) return d - 36000;
        if (d < -18000) return d + 36000;
        return d;
    endfunction

    function automatic logic [15:0] age_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = a + b;
        return s > 17'd65535 ? 16'hFFFF : s[15:0];
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic predict_follow_step();
        t_follow_result r;
        longint s, alpha, yt, pt;
        r = '0;
        r.command = CMD_NONE;
        if (cfg_enable && i_elapsed != 0) begin
            if (!i_gimbal_ready) begin
                st_active = 0;
                st_age = 0;
            end else if (i_new_frame) begin
                s = longint'(age_add(st_age, i_elapsed));
                if (!st_active) begin
                    if (i_reference_ok) begin
                        st_prev_yaw = longint'(i_yaw_angle);
                        st_prev_pitch = longint'(i_pitch_angle);
                        st_unw_yaw = 0; st_unw_pitch = 0;
                        st_filt_yaw = 0; st_filt_pitch = 0;
                        st_sent_yaw = 0; st_sent_pitch = 0;
                        st_age = 0;
                        st_active = 1;
                    end
                end else begin
                    st_unw_yaw = sat_acc(st_unw_yaw + wrap_delta(i_yaw_angle - st_prev_yaw));
                    st_unw_pitch = sat_acc(st_unw_pitch
                        + wrap_delta(i_pitch_angle - st_prev_pitch));
                    st_prev_yaw = longint'(i_yaw_angle);
                    st_prev_pitch = longint'(i_pitch_angle);
                    alpha = (s <<< 16) / (longint'(cfg_tau) + s);
                    st_filt_yaw = sat_acc(st_filt_yaw
                        + round_div(alpha * (st_unw_yaw - st_filt_yaw), 16));
                    st_filt_pitch = sat_acc(st_filt_pitch
                        + round_div(alpha * (st_unw_pitch - st_filt_pitch), 16));
                    st_age = 0;
                    yt = sat_acc(round_div(st_filt_yaw * cfg_yaw_gain, 8));
                    pt = sat_acc(round_div(st_filt_pitch * cfg_pitch_gain, 8));
                    if (mag(yt - st_sent_yaw) >= longint'(cfg_deadband)
                        || mag(pt - st_sent_pitch) >= longint'(cfg_deadband)) begin
                        st_sent_yaw = yt;
                        st_sent_pitch = pt;
                        r.command = CMD_SET;
                        r.yaw_target = 24'(yt);
                        r.pitch_target = 24'(pt);
                    end
                end
            end else begin
                st_age = age_add(st_age, i_elapsed);
                if (st_active && st_age > cfg_timeout) begin
                    r.command = CMD_HOLD;
                    st_active = 0;
                end
            end
        end
        r.following = st_active;
        r.smoothed_yaw = 24'(st_filt_yaw);
        r.smoothed_pitch = 24'(st_filt_pitch);
        r.frame_age = st_age;
        target_queue.push_back(r);
    endtask

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    assign o_pending = target_queue.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_follow_result e;
        if (!i_rst_n) begin
            cfg_enable = 1; cfg_tau = 50; cfg_yaw_gain = 256; cfg_pitch_gain = 256;
            cfg_deadband = 10; cfg_timeout = 200;
            st_active = 0; st_prev_yaw = 0; st_prev_pitch = 0;
            st_unw_yaw = 0; st_unw_pitch = 0; st_filt_yaw = 0; st_filt_pitch = 0;
            st_sent_yaw = 0; st_sent_pitch = 0; st_age = AGE_RESET;
            target_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ENABLE:   cfg_enable = i_cfg_data[0];
                    REG_TAU:      cfg_tau = i_cfg_data;
                    REG_YAW_GAIN: cfg_yaw_gain = longint'($signed(i_cfg_data));
                    REG_PIT_GAIN: cfg_pitch_gain = longint'($signed(i_cfg_data));
                    REG_DEADBAND: cfg_deadband = i_cfg_data;
                    REG_TIMEOUT:  cfg_timeout = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (target_queue.size() == 0) begin
                    $display("%0t unexpected item: expected none actual command %0d",
                             $time, i_command);
                    o_fail_count++;
                end else begin
                    e = target_queue.pop_front();
                    compare_field("command", e.command, i_command);
                    compare_field("yaw_target", e.yaw_target, i_yaw_target);
                    compare_field("pitch_target", e.pitch_target, i_pitch_target);
                    compare_field("following", e.following, i_following);
                    compare_field("smoothed_yaw", e.smoothed_yaw, i_smoothed_yaw);
                    compare_field("smoothed_pitch", e.smoothed_pitch, i_smoothed_pitch);
                    compare_field("frame_age", e.frame_age, i_frame_age);
                end
            end
            if (i_in_valid && i_in_ready) predict_follow_step();
        end
    end
endmodule

FILE: sim/imu_angle_follow_filter_test.sv
// Testbench top for the IMU angle-follow filter: drives ticks, config
// writes and output stalls; the checker module predicts and compares.
// Depends on imuaf_pkg, imu_angle_follow_filter and its checker.
`timescale 1ns / 100ps
module imu_angle_follow_filter_test;
    import imuaf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [15:0] elapsed;
    logic new_frame, gimbal_ready, reference_ok;
    logic signed [15:0] yaw_angle, pitch_angle;
    logic [1:0] command;
    logic signed [23:0] yaw_target, pitch_target, smoothed_yaw, smoothed_pitch;
    logic following;
    logic [15:0] frame_age;
    int fail_count, pending;
    int send_idle_pct, recv_stall_pct;
    int idle_cycles;
    logic signed [15:0] walk_yaw, walk_pitch;

    imu_angle_follow_filter i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_elapsed(elapsed), .i_new_frame(new_frame),
        .i_yaw_angle(yaw_angle), .i_pitch_angle(pitch_angle),
        .i_gimbal_ready(gimbal_ready), .i_reference_ok(reference_ok),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_command(command), .o_yaw_target(yaw_target), .o_pitch_target(pitch_target),
        .o_following(following), .o_smoothed_yaw(smoothed_yaw),
        .o_smoothed_pitch(smoothed_pitch), .o_frame_age(frame_age)
    );

    imu_angle_follow_filter_check i_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_elapsed(elapsed), .i_new_frame(new_frame),
        .i_yaw_angle(yaw_angle), .i_pitch_angle(pitch_angle),
        .i_gimbal_ready(gimbal_ready), .i_reference_ok(reference_ok),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_command(command), .i_yaw_target(yaw_target), .i_pitch_target(pitch_target),
        .i_following(following), .i_smoothed_yaw(smoothed_yaw),
        .i_smoothed_pitch(smoothed_pitch), .i_frame_age(frame_age),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (in_valid && in_ready || out_valid && out_ready) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[imu_angle_follow_filter] ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic send_tick(logic [15:0] el, logic nf, logic signed [15:0] yw,
                             logic signed [15:0] pt, logic rdy, logic rok);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        in_valid <= 1'b1;
        elapsed <= el;
        new_frame <= nf;
        yaw_angle <= yw;
        pitch_angle <= pt;
        gimbal_ready <= rdy;
        reference_ok <= rok;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] clip_angle(int v);
        if (v > 18000) return 16'sd18000;
        if (v < -18000) return -16'sd18000;
        return 16'(v);
    endfunction

    task automatic random_tick();
        int kind;
        int step;
        kind = $urandom_range(99);
        if (kind < 70) begin
            step = $urandom_range(4000) - 2000;
            if ($urandom_range(15) == 0) step = $urandom_range(36000) - 18000;
            walk_yaw = clip_angle(walk_yaw + step);
            if (walk_yaw == 18000 && $urandom_range(1)) walk_yaw = 16'(-18000 + step % 500);
            walk_pitch = clip_angle(walk_pitch + int'($urandom_range(3000)) - 1500);
            send_tick(16'($urandom_range(20, 1)), 1'b1, walk_yaw, walk_pitch, 1'b1,
                      $urandom_range(3) != 0);
        end else if (kind < 85) begin
            send_tick(16'($urandom_range(60, 1)), 1'b0, 16'($urandom), 16'($urandom), 1'b1,
                      1'($urandom));
        end else if (kind < 92) begin
            send_tick(16'($urandom_range(65535)), 1'($urandom),
                      16'($urandom_range(36000) - 18000),
                      16'($urandom_range(36000) - 18000), $urandom_range(7) != 0,
                      1'($urandom));
        end else if (kind < 96) begin
            send_tick(16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), 1'b0,
                      1'($urandom));
        end else begin
            send_tick(16'd0, 1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                      1'($urandom));
        end
    endtask

    task automatic random_config();
        write_reg(REG_ENABLE, 16'($urandom_range(9) != 0));
        case ($urandom_range(3))
            0: write_reg(REG_TAU, 16'd0);
            1: write_reg(REG_TAU, 16'hFFFF);
            default: write_reg(REG_TAU, 16'($urandom_range(200)));
        endcase
        case ($urandom_range(4))
            0: write_reg(REG_YAW_GAIN, 16'h8000);
            1: write_reg(REG_YAW_GAIN, 16'h7FFF);
            2: write_reg(REG_YAW_GAIN, 16'h0000);
            default: write_reg(REG_YAW_GAIN, 16'($urandom));
        endcase
        case ($urandom_range(4))
            0: write_reg(REG_PIT_GAIN, 16'h8000);
            1: write_reg(REG_PIT_GAIN, 16'h7FFF);
            2: write_reg(REG_PIT_GAIN, 16'h0000);
            default: write_reg(REG_PIT_GAIN, 16'($urandom));
        endcase
        case ($urandom_range(3))
            0: write_reg(REG_DEADBAND, 16'd0);
            1: write_reg(REG_DEADBAND, 16'hFFFF);
            default: write_reg(REG_DEADBAND, 16'($urandom_range(300)));
        endcase
        case ($urandom_range(3))
            0: write_reg(REG_TIMEOUT, 16'd0);
            1: write_reg(REG_TIMEOUT, 16'hFFFF);
            default: write_reg(REG_TIMEOUT, 16'($urandom_range(400)));
        endcase
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        in_valid = 1'b0; out_ready = 1'b0;
        elapsed = '0; new_frame = 0; yaw_angle = '0; pitch_angle = '0;
        gimbal_ready = 0; reference_ok = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        idle_cycles = 0;
        walk_yaw = 0; walk_pitch = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_tick(16'd5, 1'b1, 16'sd100, 16'sd100, 1'b1, 1'b0);
        send_tick(16'd5, 1'b1, 16'sd100, 16'sd100, 1'b1, 1'b1);
        send_tick(16'd0, 1'b1, 16'sd500, 16'sd500, 1'b1, 1'b1);
        send_tick(16'd10, 1'b1, 16'sd18000, -16'sd18000, 1'b1, 1'b1);
        send_tick(16'd10, 1'b1, -16'sd18000, 16'sd18000, 1'b1, 1'b1);
        send_tick(16'd10, 1'b1, 16'sd17000, -16'sd17000, 1'b1, 1'b1);
        send_tick(16'hFFFF, 1'b1, -16'sd17000, 16'sd17000, 1'b1, 1'b1);
        send_tick(16'd300, 1'b0, 16'sd0, 16'sd0, 1'b1, 1'b0);
        send_tick(16'hFFFF, 1'b0, 16'sd0, 16'sd0, 1'b1, 1'b0);
        send_tick(16'hFFFF, 1'b0, 16'sd0, 16'sd0, 1'b1, 1'b0);
        send_tick(16'd5, 1'b1, 16'sd0, 16'sd0, 1'b1, 1'b1);
        send_tick(16'd5, 1'b1, 16'sd0, 16'sd0, 1'b0, 1'b1);
        drain_results();
        write_reg(REG_DEADBAND, 16'd0);
        write_reg(REG_TAU, 16'd0);
        write_reg(REG_YAW_GAIN, 16'h7FFF);
        write_reg(REG_PIT_GAIN, 16'h8000);
        write_reg(REG_TIMEOUT, 16'd0);
        send_tick(16'd1, 1'b1, 16'sd0, 16'sd0, 1'b1, 1'b1);
        for (int k = 0; k < 8; k++)
            send_tick(16'd1, 1'b1, (k % 2) ? 16'sd18000 : -16'sd18000,
                      (k % 2) ? -16'sd18000 : 16'sd18000, 1'b1, 1'b1);
        send_tick(16'd1, 1'b0, 16'sd0, 16'sd0, 1'b1, 1'b1);
        drain_results();
        write_reg(REG_ENABLE, 16'd0);
        send_tick(16'd10, 1'b1, 16'sd10, 16'sd10, 1'b1, 1'b1);
        drain_results();
        write_reg(REG_ENABLE, 16'd1);

        for (int phase = 0; phase < 14; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 46; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 46; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            drain_results();
            random_config();
            for (int n = 0; n < 125; n++) begin
                random_tick();
                if (n == 60 && phase == 3) drain_results();
            end
        end

        drain_results();
        if (fail_count == 0) $display("[imu_angle_follow_filter] OK");
        else $display("[imu_angle_follow_filter] ERROR");
        $finish;
    end
endmodule
